[hw/rtl/max_filter_3x3_clipped_defines.svh]
// assertion macros shared by the max filter rtl
`ifndef MAX_FILTER_3X3_CLIPPED_DEFINES_SVH
`define MAX_FILTER_3X3_CLIPPED_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MF3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MF3_ASSERT(lbl, prop, msg)
`define MF3_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/mf3_pkg.sv]
// types, constants and helpers for the 3x3 max filter
package mf3_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_COLS  = 128;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int NCOLS_W   = 8;
  localparam int ROW_W     = 10;
  localparam int NROWS_W   = 11;
  localparam int ROW_LIMIT = 1024;
  localparam int NUM_CELLS = 3;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_e;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             left_ok;
    logic             right_ok;
    logic             above_ok;
    logic             below_ok;
    logic [COL_W-1:0] addr;
  } step_t;

  function automatic sample_t smax(sample_t a, sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

[hw/rtl/mf3_ram.sv]
// generic single write port ram with registered read
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mf3_cell.sv]
// one window column cell holding the vertical maximum of a column
module mf3_cell import mf3_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sample_t d_i,
  output sample_t q_o
);

  sample_t val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

[hw/rtl/mf3_ctrl.sv]
// raster counters, output scheduling and window masks
`include "max_filter_3x3_clipped_defines.svh"
module mf3_ctrl import mf3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [NROWS_W-1:0] rows_i,
  input  logic [NCOLS_W-1:0] cols_i,
  input  logic               restart_i,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  func_e              func_i,
  output logic               in_stall_o,
  output logic               shift_o,
  output step_t              step_o
);

  logic [NROWS_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0]   in_col_q, in_col_d;
  logic [NCOLS_W-1:0] fill_q, fill_d;
  logic [ROW_W-1:0]   out_row_q, out_row_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;

  logic [NCOLS_W-1:0] cols_p1;
  logic [NROWS_W-1:0] rows_p2;
  logic complete, primed, pad, accept, sample_path, flush_path;
  logic in_col_last, out_col_last, out_row_last;

  assign cols_p1  = cols_i + NCOLS_W'(1);
  assign rows_p2  = rows_i + NROWS_W'(2);
  assign complete = in_row_q >= rows_i;
  assign primed   = fill_q == cols_p1;
  assign pad      = complete && !primed;

  assign in_stall_o  = !adv_i || pad;
  assign accept      = in_valid_i && !in_stall_o;
  assign sample_path = accept && (func_i == FUNC_SAMPLE) && !complete;
  assign flush_path  = accept && complete;
  assign shift_o     = sample_path || flush_path || (pad && adv_i);

  assign in_col_last  = (NCOLS_W'(in_col_q) + NCOLS_W'(1)) == cols_i;
  assign out_col_last = (NCOLS_W'(out_col_q) + NCOLS_W'(1)) == cols_i;
  assign out_row_last = (NROWS_W'(out_row_q) + NROWS_W'(1)) == rows_i;

  always_comb begin
    step_o.emit     = (sample_path && primed) || flush_path;
    step_o.last     = flush_path && out_row_last && out_col_last;
    step_o.row      = out_row_q;
    step_o.col      = out_col_q;
    step_o.left_ok  = out_col_q != '0;
    step_o.right_ok = !out_col_last;
    step_o.above_ok = in_row_q >= NROWS_W'(2);
    step_o.below_ok = in_row_q < rows_i;
    step_o.addr     = in_col_q;
  end

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    fill_d    = fill_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (restart_i || (shift_o && step_o.last)) begin
      in_row_d  = '0;
      in_col_d  = '0;
      fill_d    = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (shift_o) begin
      if (in_col_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + NROWS_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (!primed) begin
        fill_d = fill_q + NCOLS_W'(1);
      end
      if (step_o.emit) begin
        if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      fill_q    <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      fill_q    <= fill_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  `MF3_ASSERT(fill_in_range, fill_q <= cols_p1, "fill count past the window lag")
  `MF3_ASSERT(row_in_range, in_row_q <= rows_p2, "input row count runs past the frame")
  `MF3_ASSERT_IMP(no_shift_when_held, !adv_i, !shift_o, "window shifted while pipeline held")

endmodule

[hw/rtl/max_filter_3x3_clipped.sv]
// streaming 3x3 maximum filter with the window clipped at the frame borders
// a result passes the read stage, the window stage and the output register in turn
// one word per cycle unless stalled; window lags num_cols + 1 words behind input
// frames shorter than num_cols + 1 words add fill steps at frame end, input stalled
// reset: counters cleared, num_rows = num_cols = 1, line buffers left as they are
`include "max_filter_3x3_clipped_defines.svh"
module max_filter_3x3_clipped import mf3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [SAMPLE_W-1:0] max_value_o,
  output logic [ROW_W-1:0]    out_row_o,
  output logic [COL_W-1:0]    out_col_o,
  output logic                frame_last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  logic [NROWS_W-1:0] num_rows_q, rows_eff;
  logic [NCOLS_W-1:0] num_cols_q, cols_eff;
  logic               cfg_wr;
  logic               single_col, out_at_end;

  logic    adv, shift;
  step_t   step;
  logic    a_valid_q, a_byp_q;
  step_t   a_step_q;
  sample_t a_sample_q, byp_mid_q, byp_above_q;
  logic    b_valid_q;
  step_t   b_step_q;

  logic [SAMPLE_W-1:0] rd_mid, rd_above;
  sample_t mid_eff, above_eff, col_max;
  sample_t cell_in [NUM_CELLS];
  sample_t cell_q  [NUM_CELLS];
  logic    cell_en;

  logic                out_valid_q, out_last_q;
  sample_t             out_max_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [COL_W-1:0]    out_col_q;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NROWS_W'(1);
      num_cols_q <= NCOLS_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_NUM_ROWS: num_rows_q <= pwdata[NROWS_W-1:0];
        REG_NUM_COLS: num_cols_q <= pwdata[NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_NUM_ROWS: prdata = CFG_DW'(num_rows_q);
      REG_NUM_COLS: prdata = CFG_DW'(num_cols_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    rows_eff = num_rows_q;
    if (num_rows_q == '0) begin
      rows_eff = NROWS_W'(1);
    end else if (num_rows_q > NROWS_W'(ROW_LIMIT)) begin
      rows_eff = NROWS_W'(ROW_LIMIT);
    end
    cols_eff = num_cols_q;
    if (num_cols_q == '0) begin
      cols_eff = NCOLS_W'(1);
    end else if (num_cols_q > NCOLS_W'(MAX_COLS)) begin
      cols_eff = NCOLS_W'(MAX_COLS);
    end
  end

  assign single_col = cols_eff == NCOLS_W'(1);

  assign adv = !out_valid_q || !out_stall_i;

  mf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rows_i     (rows_eff),
    .cols_i     (cols_eff),
    .restart_i  (cfg_wr),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .func_i     (func_e'(func_i)),
    .in_stall_o (in_stall_o),
    .shift_o    (shift),
    .step_o     (step)
  );

  // line buffers
  mf3_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_lb_middle (
    .clk_i   (clk_i),
    .we_i    (adv && a_valid_q),
    .waddr_i (a_step_q.addr),
    .wdata_i (a_sample_q),
    .re_i    (adv && shift),
    .raddr_i (step.addr),
    .rdata_o (rd_mid)
  );

  mf3_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_lb_above (
    .clk_i   (clk_i),
    .we_i    (adv && a_valid_q),
    .waddr_i (a_step_q.addr),
    .wdata_i (mid_eff),
    .re_i    (adv && shift),
    .raddr_i (step.addr),
    .rdata_o (rd_above)
  );

  // line buffer read stage, bypass covers a single column frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && shift) begin
      a_step_q    <= step;
      a_sample_q  <= sample_i;
      a_byp_q     <= a_valid_q && (step.addr == a_step_q.addr) && single_col;
      byp_mid_q   <= a_sample_q;
      byp_above_q <= mid_eff;
    end
  end

  assign mid_eff   = a_byp_q ? byp_mid_q : sample_t'(rd_mid);
  assign above_eff = a_byp_q ? byp_above_q : sample_t'(rd_above);
  assign col_max   = smax(mid_eff,
                          smax(a_step_q.above_ok ? above_eff : mid_eff,
                               a_step_q.below_ok ? a_sample_q : mid_eff));

  // window column cells: right, centre, left
  assign cell_en = adv && a_valid_q;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = col_max;
    end else begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end
    mf3_cell u_cell (
      .clk_i (clk_i),
      .en_i  (cell_en),
      .d_i   (cell_in[k]),
      .q_o   (cell_q[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q && a_step_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_valid_q) begin
      b_step_q <= a_step_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      out_max_q  <= smax(cell_q[1],
                         smax(b_step_q.left_ok ? cell_q[2] : cell_q[1],
                              b_step_q.right_ok ? cell_q[0] : cell_q[1]));
      out_row_q  <= b_step_q.row;
      out_col_q  <= b_step_q.col;
      out_last_q <= b_step_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_value_o  = out_max_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

  assign out_at_end = ((NCOLS_W'(out_col_o) + NCOLS_W'(1)) == cols_eff) &&
                      ((NROWS_W'(out_row_o) + NROWS_W'(1)) == rows_eff);

  `MF3_ASSERT_IMP(last_at_corner, out_valid_o && frame_last_o, out_at_end, "frame end misplaced")
  `MF3_ASSERT_IMP(bypass_single_col, a_valid_q && a_byp_q, single_col, "bypass on wide frame")

endmodule

[dv/max_window_checker.sv]
// checker for the 3x3 max filter: watches both word channels and the register port
`timescale 1ns / 100ps
module max_window_checker import mf3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                func_i,
  input  sample_t             sample_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sample_t             max_value_i,
  input  logic [ROW_W-1:0]    out_row_i,
  input  logic [COL_W-1:0]    out_col_i,
  input  logic                frame_last_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [CFG_AW-1:0]   paddr_i,
  input  logic [CFG_DW-1:0]   pwdata_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  typedef struct packed {
    sample_t          max_value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filtered_t;

  sample_t            row_ring [4][MAX_COLS];
  logic [NROWS_W-1:0] rows_cfg;
  logic [NCOLS_W-1:0] cols_cfg;
  int unsigned        rx_row;
  int unsigned        rx_col;
  int unsigned        next_out;
  filtered_t          pending_windows [$];
  filtered_t          want;

  function automatic int unsigned rows_in_use();
    int unsigned r;
    r = rows_cfg;
    if (r < 1) r = 1;
    if (r > ROW_LIMIT) r = ROW_LIMIT;
    return r;
  endfunction

  function automatic int unsigned cols_in_use();
    int unsigned c;
    c = cols_cfg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  // maximum over the window around raster position pos, clipped to the frame
  function automatic filtered_t window_max(int unsigned pos, int unsigned rows,
                                           int unsigned cols, logic last);
    filtered_t   res;
    int unsigned r, c, r0, r1, c0, c1;
    sample_t     best;
    r  = pos / cols;
    c  = pos % cols;
    r0 = (r > 0) ? r - 1 : 0;
    r1 = (r + 1 < rows) ? r + 1 : rows - 1;
    c0 = (c > 0) ? c - 1 : 0;
    c1 = (c + 1 < cols) ? c + 1 : cols - 1;
    best = row_ring[r0 % 4][c0];
    for (int unsigned i = r0; i <= r1; i++) begin
      for (int unsigned j = c0; j <= c1; j++) begin
        if (row_ring[i % 4][j] > best) best = row_ring[i % 4][j];
      end
    end
    res.max_value = best;
    res.row       = ROW_W'(r);
    res.col       = COL_W'(c);
    res.last      = last;
    return res;
  endfunction

  task automatic restart_frame();
    rx_row   = 0;
    rx_col   = 0;
    next_out = 0;
  endtask

  task automatic accept_word(func_e f, sample_t s);
    int unsigned rows, cols, total, received;
    rows  = rows_in_use();
    cols  = cols_in_use();
    total = rows * cols;
    if (rx_col >= cols) rx_col = 0;
    if (f == FUNC_SAMPLE && rx_row < rows) begin
      row_ring[rx_row % 4][rx_col] = s;
      rx_col++;
      if (rx_col >= cols) begin
        rx_col = 0;
        rx_row++;
      end
      received = rx_row * cols + rx_col;
      if (received >= next_out + cols + 2 && next_out < total) begin
        pending_windows.push_back(window_max(next_out, rows, cols, 1'b0));
        next_out++;
      end
    end else if (rx_row >= rows && next_out < total) begin
      if (next_out == total - 1) begin
        pending_windows.push_back(window_max(next_out, rows, cols, 1'b1));
        restart_frame();
      end else begin
        pending_windows.push_back(window_max(next_out, rows, cols, 1'b0));
        next_out++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg = 1;
      cols_cfg = 1;
      restart_frame();
      pending_windows.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        if (paddr_i[CFG_AW-1:2] == REG_NUM_ROWS) begin
          rows_cfg = pwdata_i[NROWS_W-1:0];
          restart_frame();
        end else if (paddr_i[CFG_AW-1:2] == REG_NUM_COLS) begin
          cols_cfg = pwdata_i[NCOLS_W-1:0];
          restart_frame();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_windows.size() == 0) begin
          $error("result word with nothing expected: row %0d col %0d", out_row_i, out_col_i);
          mismatches_o++;
        end else begin
          want = pending_windows.pop_front();
          if (max_value_i !== want.max_value) begin
            $error("max_value: expected %0d, got %0d", want.max_value, max_value_i);
            mismatches_o++;
          end
          if (out_row_i !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row_i);
            mismatches_o++;
          end
          if (out_col_i !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col_i);
            mismatches_o++;
          end
          if (frame_last_i !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, frame_last_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) accept_word(func_e'(func_i), sample_i);
      pending_o = pending_windows.size();
    end
  end

endmodule

[dv/tb_max_filter_3x3_clipped.sv]
// stimulus and verdict for the 3x3 max filter, with the checker beside the block
`timescale 1ns / 100ps
module tb_max_filter_3x3_clipped;
  import mf3_pkg::*;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  func_e              func      = FUNC_SAMPLE;
  sample_t            sample    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sample_t            max_value;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               frame_last;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [CFG_AW-1:0]  paddr     = '0;
  logic [CFG_DW-1:0]  pwdata    = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;
  int unsigned        pending;
  int unsigned        mismatches;

  bit                 quiet = 1'b0;
  int unsigned        frame_rows = 1;
  int unsigned        frame_cols = 1;
  int unsigned        words_sent;

  max_filter_3x3_clipped i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .max_value_o  (max_value),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .frame_last_o (frame_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  max_window_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .max_value_i  (max_value),
    .out_row_i    (out_row),
    .out_col_i    (out_col),
    .frame_last_i (frame_last),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // receiver back-pressure
  initial begin : stall_gen
    int unsigned n;
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(func_e f, sample_t s);
    int unsigned gap;
    logic        taken;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    sample   <= s;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // drained, then long enough for any fill cycles to finish
  task automatic settle();
    wait_drained();
    repeat (2 * MAX_COLS) @(posedge clk);
  endtask

  task automatic cfg_write(reg_e r, logic [CFG_DW-1:0] value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // junk in the unused upper bits of each write
  task automatic configure(int unsigned rows_raw, int unsigned cols_raw);
    settle();
    cfg_write(REG_NUM_ROWS, ($urandom() & ~32'h7ff) | (rows_raw & 32'h7ff));
    cfg_write(REG_NUM_COLS, ($urandom() & ~32'hff) | (cols_raw & 32'hff));
    frame_rows = rows_raw & 32'h7ff;
    frame_cols = cols_raw & 32'hff;
    if (frame_rows < 1) frame_rows = 1;
    if (frame_rows > ROW_LIMIT) frame_rows = ROW_LIMIT;
    if (frame_cols < 1) frame_cols = 1;
    if (frame_cols > MAX_COLS) frame_cols = MAX_COLS;
  endtask

  // stop_at below the frame size leaves the frame unfinished
  task automatic run_frame(int unsigned stop_at);
    int unsigned total, tail;
    total = frame_rows * frame_cols;
    for (int unsigned k = 0; k < total && k < stop_at; k++) begin
      if ($urandom_range(0, 19) == 0) send_word(FUNC_FLUSH, rand_sample());
      if ($urandom_range(0, 99) == 0) wait_drained();
      send_word(FUNC_SAMPLE, rand_sample());
      words_sent++;
    end
    if (stop_at >= total) begin
      tail = (total < frame_cols + 1) ? total : frame_cols + 1;
      repeat (tail) begin
        // a sample once the frame is in counts as a flush
        if ($urandom_range(0, 4) == 0) send_word(FUNC_SAMPLE, rand_sample());
        else send_word(FUNC_FLUSH, rand_sample());
        words_sent++;
      end
      if ($urandom_range(0, 9) == 0) send_word(FUNC_FLUSH, rand_sample());
    end
  endtask

  initial begin : stimulus
    int unsigned rows_raw, cols_raw, total, cut;
    bit          need_cfg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // 1x1 after reset; flush before anything is in
    send_word(FUNC_FLUSH, '0);
    send_word(FUNC_SAMPLE, SAMPLE_MIN);
    send_word(FUNC_FLUSH, SAMPLE_MAX);

    configure(2, 2);
    send_word(FUNC_SAMPLE, SAMPLE_MAX);
    send_word(FUNC_FLUSH, '0);
    send_word(FUNC_SAMPLE, SAMPLE_MIN);
    send_word(FUNC_SAMPLE, '0);
    send_word(FUNC_SAMPLE, '1);
    send_word(FUNC_SAMPLE, sample_t'(16'h5555));
    send_word(FUNC_FLUSH, '0);
    send_word(FUNC_FLUSH, '0);
    send_word(FUNC_FLUSH, '1);

    // partial frame cut short by a register write
    configure(3, 3);
    repeat (4) send_word(FUNC_SAMPLE, rand_sample());
    settle();
    cfg_write(REG_NUM_COLS, 32'd3);
    for (int unsigned k = 0; k < 9; k++) begin
      send_word(FUNC_SAMPLE, k[0] ? sample_t'(16'h5555) : sample_t'(16'haaaa));
    end
    repeat (4) send_word(FUNC_FLUSH, '0);

    // register extremes and clamping
    configure(2047, 1);
    run_frame(40);
    configure(2, 255);
    run_frame(frame_rows * frame_cols);
    configure(1, 128);
    run_frame(20);
    configure(0, 0);
    run_frame(frame_rows * frame_cols);

    need_cfg   = 1'b1;
    while (words_sent < 700) begin
      if (need_cfg || $urandom_range(0, 9) < 6) begin
        rows_raw = $urandom_range(1, 6);
        cols_raw = $urandom_range(1, 12);
        case ($urandom_range(0, 15))
          0: rows_raw = 0;
          1: cols_raw = 0;
          2: begin
            rows_raw = $urandom_range(1, 2);
            cols_raw = $urandom_range(100, 255);
          end
          default: ;
        endcase
        configure(rows_raw, cols_raw);
      end
      quiet    = ($urandom_range(0, 4) == 0);
      total    = frame_rows * frame_cols;
      cut      = ($urandom_range(0, 11) == 0) ? $urandom_range(0, total - 1) : total;
      need_cfg = (cut < total);
      run_frame(cut);
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS max_filter_3x3_clipped");
    end else begin
      $display("FAIL max_filter_3x3_clipped");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL max_filter_3x3_clipped");
    $finish;
  end

endmodule
